[rtl/utf8v_pkg.sv]
`default_nettype none

package utf8v_pkg;

   localparam int unsigned MAX_STRING_BYTES = 65535;
   // byte index at which a string counts as too long
   localparam logic [15:0] POS_LIMIT =
      16'((MAX_STRING_BYTES < 65535) ? MAX_STRING_BYTES : 65535);

   localparam logic [30:0] CP_TOP       = 31'h0011_0000;
   localparam logic [30:0] SURR_MASK    = 31'h7FFF_F800;
   localparam logic [30:0] SURR_BASE    = 31'h0000_D800;
   localparam logic [30:0] NONCHAR_LO   = 31'h0000_FDD0;
   localparam logic [30:0] NONCHAR_HI   = 31'h0000_FDEF;
   localparam logic [30:0] NONCHAR_MASK = 31'h0000_FFFE;

   localparam logic [30:0] LEN2_MIN = 31'h0000_0080;
   localparam logic [30:0] LEN3_MIN = 31'h0000_0800;
   localparam logic [30:0] LEN4_MIN = 31'h0001_0000;
   localparam logic [30:0] LEN5_MIN = 31'h0020_0000;
   localparam logic [30:0] LEN6_MIN = 31'h0400_0000;

   typedef struct packed {
      logic [2:0] len;
      logic [7:0] mask;
   } lead_type;

   // shortest encoding length of a code point
   function automatic logic [2:0] min_len(input logic [30:0] cp);
      logic [2:0] n;
      if (cp < LEN2_MIN)      n = 3'd1;
      else if (cp < LEN3_MIN) n = 3'd2;
      else if (cp < LEN4_MIN) n = 3'd3;
      else if (cp < LEN5_MIN) n = 3'd4;
      else if (cp < LEN6_MIN) n = 3'd5;
      else                    n = 3'd6;
      return n;
   endfunction

   function automatic logic cp_allowed(input logic [30:0] cp);
      return (cp < CP_TOP) &&
             ((cp & SURR_MASK) != SURR_BASE) &&
             ((cp < NONCHAR_LO) || (cp > NONCHAR_HI)) &&
             ((cp & NONCHAR_MASK) != NONCHAR_MASK);
   endfunction

   // len of zero marks a byte that cannot start a character
   function automatic lead_type lead_decode(input logic [7:0] c);
      lead_type d;
      if (c[7] == 1'b0)                d = '{3'd1, 8'h7F};
      else if (c[7:5] == 3'b110)       d = '{3'd2, 8'h1F};
      else if (c[7:4] == 4'b1110)      d = '{3'd3, 8'h0F};
      else if (c[7:3] == 5'b11110)     d = '{3'd4, 8'h07};
      else if (c[7:2] == 6'b111110)    d = '{3'd5, 8'h03};
      else if (c[7:1] == 7'b1111110)   d = '{3'd6, 8'h01};
      else                             d = '{3'd0, 8'h00};
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/utf8_stream_validator.sv]
// a request is registered on accept; a string's result is registered into the result
//    register when the string's last byte leaves the input register
// throughput: one byte per cycle; only a last byte waits on a full result register
// reset (synchronous, active high) clears all string state and both valid flags
`default_nettype none

module utf8_stream_validator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] valid_prefix_length
   output logic             rsp_tuser    // [0] is_valid
);

   logic        req_valid_ff, req_valid_in;
   logic [7:0]  req_data_ff;
   logic        req_last_ff;

   logic        failed_ff, failed_in;
   logic [2:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]  seq_len_ff, seq_len_in;
   logic [30:0] code_point_ff, code_point_in;
   logic [15:0] byte_pos_ff, byte_pos_in;
   logic [15:0] char_start_ff, char_start_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_is_valid_ff;
   logic [15:0] rsp_length_ff;

   logic        advance;
   logic        take_req;
   logic        fin_failed;
   logic [15:0] fin_length;

   // a byte leaves the input register unless it is a last byte facing a full result that is not being taken
   assign advance    = req_valid_ff && (!req_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   always_comb begin
      utf8v_pkg::lead_type lead;
      logic                finish;
      logic [2:0]          fail_left;
      lead          = utf8v_pkg::lead_decode(req_data_ff);
      finish        = 1'b0;
      fail_left     = bytes_left_ff;
      failed_in     = failed_ff;
      bytes_left_in = bytes_left_ff;
      seq_len_in    = seq_len_ff;
      code_point_in = code_point_ff;
      byte_pos_in   = byte_pos_ff;
      char_start_in = char_start_ff;
      if (!failed_ff) begin
         if (byte_pos_ff >= utf8v_pkg::POS_LIMIT) begin
            if (bytes_left_ff == 3'd0) begin
               char_start_in = byte_pos_ff;
            end
            failed_in = 1'b1;
         end else if (bytes_left_ff == 3'd0) begin
            char_start_in = byte_pos_ff;
            if (req_data_ff == 8'h00 || lead.len == 3'd0) begin
               failed_in = 1'b1;
            end else begin
               seq_len_in    = lead.len;
               code_point_in = {23'd0, req_data_ff & lead.mask};
               bytes_left_in = lead.len - 3'd1;
               finish        = (lead.len == 3'd1);
               byte_pos_in   = byte_pos_ff + 16'd1;
            end
         end else begin
            if (req_data_ff[7:6] != 2'b10) begin
               failed_in = 1'b1;
            end else begin
               code_point_in = {code_point_ff[24:0], req_data_ff[5:0]};
               bytes_left_in = bytes_left_ff - 3'd1;
               finish        = (bytes_left_in == 3'd0);
               byte_pos_in   = byte_pos_ff + 16'd1;
            end
         end
         if (finish && ((utf8v_pkg::min_len(code_point_in) != seq_len_in) ||
                        !utf8v_pkg::cp_allowed(code_point_in))) begin
            failed_in = 1'b1;
         end
      end
      fail_left  = bytes_left_in;
      // an unfinished character at the end fails the string
      fin_failed = failed_in || (fail_left != 3'd0);
      fin_length = fin_failed ? char_start_in : byte_pos_in;
   end

   always_comb begin
      req_valid_in = take_req ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      if (advance && req_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         failed_ff     <= 1'b0;
         bytes_left_ff <= 3'd0;
         seq_len_ff    <= 3'd0;
         code_point_ff <= 31'd0;
         byte_pos_ff   <= 16'd0;
         char_start_ff <= 16'd0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (req_last_ff) begin
               // string done, start the next one clean
               failed_ff     <= 1'b0;
               bytes_left_ff <= 3'd0;
               seq_len_ff    <= 3'd0;
               code_point_ff <= 31'd0;
               byte_pos_ff   <= 16'd0;
               char_start_ff <= 16'd0;
            end else begin
               failed_ff     <= failed_in;
               bytes_left_ff <= bytes_left_in;
               seq_len_ff    <= seq_len_in;
               code_point_ff <= code_point_in;
               byte_pos_ff   <= byte_pos_in;
               char_start_ff <= char_start_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         req_data_ff <= req_tdata;
         req_last_ff <= req_tlast;
      end
      if (advance && req_last_ff) begin
         rsp_is_valid_ff <= !fin_failed;
         rsp_length_ff   <= fin_length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_length_ff;
   assign rsp_tuser  = rsp_is_valid_ff;

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && req_last_ff) |=> (byte_pos_ff == 16'd0 && !failed_ff &&
                                    bytes_left_ff == 3'd0))
      else $error("string state not cleared after last byte");

   a_left_below_len: assert property (@(posedge clock) disable iff (reset)
      (bytes_left_ff != 3'd0) |-> (bytes_left_ff < seq_len_ff))
      else $error("continuation count exceeds character length");

   a_valid_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_valid_ff) |-> (rsp_length_ff != 16'd0))
      else $error("valid verdict with empty prefix");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(byte_pos_ff) && $stable(failed_ff))
      else $error("string state moved without a byte");
`endif

endmodule

`default_nettype wire
